// ===== hdl/plst_pkg.sv =====
`default_nettype none

package plst_pkg;

	// Command codes carried in the operation field.
	typedef enum logic [3:0] {
		OP_PUSH_BACK  = 4'd0,
		OP_PUSH_FRONT = 4'd1,
		OP_INSERT     = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_POP_FRONT  = 4'd4,
		OP_ERASE      = 4'd5,
		OP_FRONT      = 4'd6,
		OP_BACK       = 4'd7,
		OP_READ_AT    = 4'd8,
		OP_REPLACE    = 4'd9,
		OP_CLEAR      = 4'd10
	} op_e;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_e;

	// What every cell of the row does in this cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_INSERT,
		CELL_ERASE
	} cell_op_e;

	typedef struct packed {
		cell_op_e op;
		logic     rd_en;
	} cell_ctl_t;

	// One command transaction.
	typedef struct packed {
		logic [3:0]         operation;
		logic [8:0]         position;
		logic signed [31:0] data_in;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic signed [31:0] data_out;
		logic [1:0]         status;
		logic [8:0]         item_count;
		logic               is_empty;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hdl/plst_cell.sv =====
`default_nettype none

module plst_cell import plst_pkg::*; #(
	parameter int INDEX = 0,
	parameter int IW    = 8,
	parameter int DW    = 32
) (
	input  wire logic            clk,
	input  wire cell_ctl_t       ctl,
	input  wire logic [IW-1:0]   wr_idx,
	input  wire logic [IW-1:0]   rd_idx,
	input  wire logic [DW-1:0]   din,
	input  wire logic [DW-1:0]   left_val,
	input  wire logic [DW-1:0]   right_val,
	output logic      [DW-1:0]   val,
	output logic      [DW-1:0]   rd_val
);

	logic [DW-1:0] val_q;
	logic          at_pos;
	logic          past_pos;

	// Where this cell sits relative to the addressed list position.
	assign at_pos   = (wr_idx == IW'(INDEX));
	assign past_pos = (IW'(INDEX) > wr_idx);

	// Shift toward the back on insert, toward the front on erase, or write in place.
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_WRITE: begin
				if (at_pos) val_q <= din;
			end
			CELL_INSERT: begin
				if (past_pos) val_q <= left_val;
				else if (at_pos) val_q <= din;
			end
			CELL_ERASE: begin
				if (past_pos || at_pos) val_q <= right_val;
			end
			default: begin
			end
		endcase
	end

	assign val = val_q;

	// Only the addressed cell drives its value onto the read tree.
	assign rd_val = (ctl.rd_en && (rd_idx == IW'(INDEX))) ? val_q : '0;

endmodule

`default_nettype wire

// ===== hdl/positional_list_store_top.sv =====
`default_nettype none

// A command taken at a clock edge updates the row of cells at that edge; its read passes the
// group registers and then the output registers before its result is strobed on done.
// Throughput: one command per cycle; busy stays low, since every cell shifts or writes at
// the accepting edge and the read goes through a two-level registered OR tree over the cells.
// Reset: arst_n clears the entry count and the pipeline valid bits; cell contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
module positional_list_store_top import plst_pkg::*; #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire cmd_t cmd,
	output logic      done,
	output rsp_t      rsp
);

	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 9) ? CW : 9;
	localparam int GRP  = 16;
	localparam int NG   = (DEPTH + GRP - 1) / GRP;

	logic            accept;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cnt_d;
	logic [CW-1:0]   cnt_dec;
	logic [CMPW-1:0] posx;
	logic [CMPW-1:0] cntx;
	logic            full;
	logic            empty;
	status_e         st_d;
	cell_ctl_t       ctl;
	cell_op_e        op_d;
	logic            rd_en_d;
	logic [IW-1:0]   wr_idx_d;
	logic [IW-1:0]   rd_idx_d;
	logic [DATA_WIDTH-1:0] din;

	logic [DATA_WIDTH-1:0] vals    [DEPTH];
	logic [DATA_WIDTH-1:0] rd_vals [DEPTH];
	logic [DATA_WIDTH-1:0] grp_or  [NG];
	logic [DATA_WIDTH-1:0] grp_s1  [NG];
	logic [DATA_WIDTH-1:0] rd_word;

	logic            valid_s1;
	status_e         st_s1;
	logic [CW-1:0]   cnt_s1;
	logic            done_s2;
	rsp_t            rsp_s2;

	// The row of cells takes a new command in every cycle.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign posx    = CMPW'(cmd.position);
	assign cntx    = CMPW'(cnt_q);
	assign full    = (cntx >= CMPW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign cnt_dec = cnt_q - CW'(1);
	assign din     = DATA_WIDTH'(cmd.data_in);

	// Command decode: status, the row operation, the read address and the next count.
	always_comb begin
		st_d     = ST_OK;
		op_d     = CELL_HOLD;
		rd_en_d  = 1'b0;
		wr_idx_d = '0;
		rd_idx_d = '0;
		cnt_d    = cnt_q;
		case (cmd.operation)
			OP_PUSH_BACK: begin
				if (full) st_d = ST_FULL;
				else begin
					op_d     = CELL_WRITE;
					wr_idx_d = cnt_q[IW-1:0];
					cnt_d    = cnt_q + CW'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) st_d = ST_FULL;
				else begin
					op_d  = CELL_INSERT;
					cnt_d = cnt_q + CW'(1);
				end
			end
			OP_INSERT: begin
				if (posx > cntx) st_d = ST_RANGE;
				else if (full) st_d = ST_FULL;
				else begin
					op_d     = CELL_INSERT;
					wr_idx_d = posx[IW-1:0];
					cnt_d    = cnt_q + CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) st_d = ST_RANGE;
				else begin
					rd_en_d  = 1'b1;
					rd_idx_d = cnt_dec[IW-1:0];
					cnt_d    = cnt_dec;
				end
			end
			OP_POP_FRONT: begin
				if (empty) st_d = ST_RANGE;
				else begin
					op_d    = CELL_ERASE;
					rd_en_d = 1'b1;
					cnt_d   = cnt_dec;
				end
			end
			OP_ERASE: begin
				if (posx >= cntx) st_d = ST_RANGE;
				else begin
					op_d     = CELL_ERASE;
					wr_idx_d = posx[IW-1:0];
					rd_en_d  = 1'b1;
					rd_idx_d = posx[IW-1:0];
					cnt_d    = cnt_dec;
				end
			end
			OP_FRONT: begin
				if (empty) st_d = ST_RANGE;
				else rd_en_d = 1'b1;
			end
			OP_BACK: begin
				if (empty) st_d = ST_RANGE;
				else begin
					rd_en_d  = 1'b1;
					rd_idx_d = cnt_dec[IW-1:0];
				end
			end
			OP_READ_AT: begin
				if (posx >= cntx) st_d = ST_RANGE;
				else begin
					rd_en_d  = 1'b1;
					rd_idx_d = posx[IW-1:0];
				end
			end
			OP_REPLACE: begin
				if (posx >= cntx) st_d = ST_RANGE;
				else begin
					op_d     = CELL_WRITE;
					wr_idx_d = posx[IW-1:0];
				end
			end
			OP_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
				st_d = ST_RANGE;
			end
		endcase
	end

	// Cells act only on an accepted command.
	assign ctl.op    = accept ? op_d : CELL_HOLD;
	assign ctl.rd_en = accept && rd_en_d;

	// Row of cells, each linked to its front and back neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = vals[i];
		end else begin : g_mid_l
			assign left_w = vals[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = vals[i];
		end else begin : g_mid_r
			assign right_w = vals[i+1];
		end

		plst_cell #(
			.INDEX (i),
			.IW    (IW),
			.DW    (DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.wr_idx    (wr_idx_d),
			.rd_idx    (rd_idx_d),
			.din       (din),
			.left_val  (left_w),
			.right_val (right_w),
			.val       (vals[i]),
			.rd_val    (rd_vals[i])
		);
	end

	// First level of the read tree: OR within each group of cells.
	for (genvar g = 0; g < NG; g++) begin : g_grp
		always_comb begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < DEPTH) grp_or[g] = grp_or[g] | rd_vals[g * GRP + k];
			end
		end

		always_ff @(posedge clk) begin
			grp_s1[g] <= grp_or[g];
		end
	end

	// Count register and first pipeline stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		st_s1  <= st_d;
		cnt_s1 <= cnt_d;
	end

	// Second level of the read tree: OR over the group registers.
	always_comb begin
		rd_word = '0;
		for (int g = 0; g < NG; g++) rd_word = rd_word | grp_s1[g];
	end

	// Output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		rsp_s2.data_out   <= 32'($signed(rd_word));
		rsp_s2.status     <= st_s1;
		rsp_s2.item_count <= 9'(cnt_s1);
		rsp_s2.is_empty   <= (cnt_s1 == '0);
	end

	assign done = done_s2;
	assign rsp  = rsp_s2;

	// The count never passes the capacity of the row.
	assert property (@(posedge clk) disable iff (!arst_n) CMPW'(cnt_q) <= CMPW'(DEPTH))
		else $error("entry count exceeds capacity");

	// Every accepted command yields exactly one result, strobed in the cycle after its first-stage valid bit.
	assert property (@(posedge clk) disable iff (!arst_n) valid_s1 |=> done)
		else $error("result strobe missing");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(valid_s1))
		else $error("result strobe without command");

	// A failed command never returns data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.data_out == '0))
		else $error("data returned with error status");

	// A full status is only given when the row is at capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && st_s1 == ST_FULL) |-> (CMPW'(cnt_s1) == CMPW'(DEPTH)))
		else $error("full status below capacity");

	// The count moves by at most one, except on clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		((cnt_q != $past(cnt_q)) && (cnt_q != '0)) |->
		((cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == $past(cnt_q) - CW'(1))))
		else $error("entry count jumped");

endmodule

`default_nettype wire
